// File: rtl/core/psd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psd_pkg
// shared types and constants of the periodic slot dispatcher
// ----------------------------------------------------------------------------
package psd_pkg;

   localparam int TICK_W       = 32;
   localparam int PERIOD_W     = 31;
   localparam int CNT_W        = 3;
   localparam int SLOT_W       = 2;
   localparam int PERIOD_SLOTS = 4;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 32;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_SLOTS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LATE_FIRES   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_SLOT0 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_SLOT1 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_SLOT2 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_SLOT3 = 3'd5;

   localparam logic [TICK_W-1:0] MISS_MAX = '1;

   typedef enum logic [1:0] {
      OP_INIT     = 2'd0,
      OP_START    = 2'd1,
      OP_STOP     = 2'd2,
      OP_DISPATCH = 2'd3
   } op_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } state_type;

   typedef struct packed {
      op_type              operation;
      logic [TICK_W-1:0]   now_tick;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot_id;
      logic                fired;
      logic                missed;
      logic [TICK_W-1:0]   miss_total;
      logic                last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic accept;   // input transfer this cycle
      logic step;     // evaluate the current slot and move on
      logic flush;    // hand the held result to the output as the final one
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic start_scan;   // offered item is a dispatch while running
      logic scan_done;    // no more slots to visit
      logic cur_hit;      // current slot is due
      logic pend_valid;   // a result is held back
      logic out_free;     // output register can take a result this cycle
   } status_type;

endpackage : psd_pkg
`default_nettype wire

// File: rtl/core/psd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psd_ctrl
// sequencer of the dispatcher: input acceptance and the slot scan
// ----------------------------------------------------------------------------
module psd_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire psd_pkg::status_type status,
   output psd_pkg::cmd_type        cmd,
   output logic                    busy
);
   import psd_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy       = 1'b0;
            cmd.accept = req_valid;
            if (req_valid && status.start_scan) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               if (!status.pend_valid) begin
                  state_in = ST_IDLE;
               end else if (status.out_free) begin
                  cmd.flush = 1'b1;
                  state_in  = ST_IDLE;
               end
            end else if (!(status.cur_hit && status.pend_valid && !status.out_free)) begin
               // wait only when a new result would push an unsent one
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule : psd_ctrl
`default_nettype wire

// File: rtl/core/psd_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psd_datapath
// slot table, configuration registers, slot evaluation and result registers
// ----------------------------------------------------------------------------
module psd_datapath #(
   parameter int NUM_SLOTS      = 4,
   parameter int DISPATCH_LIMIT = 4
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire psd_pkg::cmd_type                  cmd,
   output psd_pkg::status_type                    status,
   input  wire psd_pkg::req_type                  req_data,
   input  wire logic                              csr_valid,
   input  wire logic [psd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [psd_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output psd_pkg::rsp_type                       rsp_data
);
   import psd_pkg::*;

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int FC_W  = $clog2(DISPATCH_LIMIT + 1);

   // configuration
   logic [CNT_W-1:0]    active_ff;
   logic                late_fires_ff;
   logic [PERIOD_W-1:0] period_ff [PERIOD_SLOTS];

   // slot table and run flags
   logic [TICK_W-1:0]   due_time_ff [NUM_SLOTS];
   logic [TICK_W-1:0]   due_time_in [NUM_SLOTS];
   logic [TICK_W-1:0]   miss_count_ff [NUM_SLOTS];
   logic [TICK_W-1:0]   miss_count_in [NUM_SLOTS];
   logic                running_ff, running_in;
   logic                armed_ff, armed_in;

   // scan state
   logic [TICK_W-1:0]   now_ff, now_in;
   logic [CNT_W-1:0]    scan_idx_ff, scan_idx_in;
   logic [FC_W-1:0]     fired_cnt_ff, fired_cnt_in;
   logic                pend_valid_ff, pend_valid_in;
   rsp_type             pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   // evaluation of the current slot
   logic [CNT_W-1:0]    limit;
   logic [IDX_W-1:0]    cur_idx;
   logic [PERIOD_W-1:0] cur_period;
   logic [TICK_W-1:0]   cur_due;
   logic [TICK_W-1:0]   cur_miss;
   logic [TICK_W-1:0]   late;
   logic                cur_hit;
   logic                cur_missed;
   logic                cur_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= '0;
         late_fires_ff <= 1'b0;
         for (int i = 0; i < PERIOD_SLOTS; i++) begin
            period_ff[i] <= '0;
         end
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ACTIVE_SLOTS: active_ff     <= csr_data[CNT_W-1:0];
            CSR_LATE_FIRES:   late_fires_ff <= csr_data[0];
            CSR_PERIOD_SLOT0: period_ff[0]  <= csr_data[PERIOD_W-1:0];
            CSR_PERIOD_SLOT1: period_ff[1]  <= csr_data[PERIOD_W-1:0];
            CSR_PERIOD_SLOT2: period_ff[2]  <= csr_data[PERIOD_W-1:0];
            CSR_PERIOD_SLOT3: period_ff[3]  <= csr_data[PERIOD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign limit = (active_ff > CNT_W'(NUM_SLOTS)) ? CNT_W'(NUM_SLOTS) : active_ff;

   assign cur_idx    = scan_idx_ff[IDX_W-1:0];
   assign cur_period = period_ff[scan_idx_ff[SLOT_W-1:0]];
   assign cur_due    = due_time_ff[cur_idx];
   assign cur_miss   = miss_count_ff[cur_idx];
   assign late       = now_ff - cur_due;
   assign cur_hit    = (cur_period != '0) && !late[TICK_W-1];
   assign cur_missed = late >= {1'b0, cur_period};
   assign cur_fire   = !cur_missed || late_fires_ff;

   assign status.start_scan = (req_data.operation == OP_DISPATCH) && running_ff;
   assign status.scan_done  = (scan_idx_ff >= limit) ||
                              (fired_cnt_ff == FC_W'(DISPATCH_LIMIT));
   assign status.cur_hit    = cur_hit;
   assign status.pend_valid = pend_valid_ff;
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      due_time_in   = due_time_ff;
      miss_count_in = miss_count_ff;
      running_in    = running_ff;
      armed_in      = armed_ff;
      now_in        = now_ff;
      scan_idx_in   = scan_idx_ff;
      fired_cnt_in  = fired_cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (cmd.accept) begin
         case (req_data.operation)
            OP_INIT: begin
               if (!running_ff) begin
                  for (int i = 0; i < NUM_SLOTS; i++) begin
                     miss_count_in[i] = '0;
                     due_time_in[i]   = (CNT_W'(i) < limit) ?
                                        req_data.now_tick + {1'b0, period_ff[i]} : '0;
                  end
                  armed_in = 1'b1;
               end
            end
            OP_START: begin
               if (!running_ff && armed_ff && (limit != '0)) begin
                  for (int i = 0; i < NUM_SLOTS; i++) begin
                     if (CNT_W'(i) < limit) begin
                        due_time_in[i] = req_data.now_tick + {1'b0, period_ff[i]};
                     end
                  end
                  running_in = 1'b1;
               end
            end
            OP_STOP: begin
               running_in = 1'b0;
            end
            OP_DISPATCH: begin
               now_in        = req_data.now_tick;
               scan_idx_in   = '0;
               fired_cnt_in  = '0;
               pend_valid_in = 1'b0;
            end
            default: begin
            end
         endcase
      end

      if (cmd.step) begin
         scan_idx_in = scan_idx_ff + CNT_W'(1);
         if (cur_hit) begin
            if (cur_missed) begin
               if (cur_miss != MISS_MAX) begin
                  miss_count_in[cur_idx] = cur_miss + TICK_W'(1);
               end
               due_time_in[cur_idx] = now_ff + {1'b0, cur_period};
            end else begin
               due_time_in[cur_idx] = cur_due + {1'b0, cur_period};
            end
            if (cur_fire) begin
               fired_cnt_in = fired_cnt_ff + FC_W'(1);
            end
            // the held result is known not to be the final one now
            if (pend_valid_ff) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
            end
            pend_valid_in      = 1'b1;
            pend_in.slot_id    = scan_idx_ff[SLOT_W-1:0];
            pend_in.fired      = cur_fire;
            pend_in.missed     = cur_missed;
            pend_in.miss_total = miss_count_in[cur_idx];
            pend_in.last       = 1'b0;
         end
      end

      if (cmd.flush) begin
         rsp_in        = pend_ff;
         rsp_in.last   = 1'b1;
         rsp_valid_in  = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            due_time_ff[i]   <= '0;
            miss_count_ff[i] <= '0;
         end
         running_ff    <= 1'b0;
         armed_ff      <= 1'b0;
         scan_idx_ff   <= '0;
         fired_cnt_ff  <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         due_time_ff   <= due_time_in;
         miss_count_ff <= miss_count_in;
         running_ff    <= running_in;
         armed_ff      <= armed_in;
         scan_idx_ff   <= scan_idx_in;
         fired_cnt_ff  <= fired_cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff  <= now_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule : psd_datapath
`default_nettype wire

// File: rtl/core/periodic_slot_dispatcher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_slot_dispatcher
// table of periodic slots with due times and missed-deadline counts
// ----------------------------------------------------------------------------
// The block works on one request at a time. Init, start and stop, and a
// dispatch while stopped, finish in the cycle they are taken and give no transfer on rsp_.
// A dispatch while running makes the sequencer scan the slots (at most the
// active count, capped at NUM_SLOTS, and cut short once DISPATCH_LIMIT slots
// have fired): it evaluates one slot per cycle against the shared subtract
// and compare unless the rsp_ side holds the scan, and a final step hands over
// the last result. Each result is held back one step so that the final one
// can carry its last flag; a stalled rsp_ side pauses the scan only when a
// new or final result would overwrite one not yet taken. The output
// register lets the next request in while the final result still waits.
// Configuration writes are always taken (csr_ready is tied high) and are
// meant to happen only while no dispatch is in flight.
// ----------------------------------------------------------------------------
module periodic_slot_dispatcher #(
   parameter int NUM_SLOTS      = 4,
   parameter int DISPATCH_LIMIT = 4
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire psd_pkg::req_type                  req_data,
   // result channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output psd_pkg::rsp_type                       rsp_data,
   // configuration write channel
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [psd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [psd_pkg::CSR_DATA_W-1:0]    csr_data
);
   import psd_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       busy;

   // writes are always accepted
   assign csr_ready = 1'b1;

   // sequencer: idle / scan
   psd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy)
   );

   // a request transfer only happens from idle
   assign req_stall = busy;

   // slot table, evaluation and output register
   psd_datapath #(
      .NUM_SLOTS      (NUM_SLOTS),
      .DISPATCH_LIMIT (DISPATCH_LIMIT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // the final hand-over always shows up as a last-flagged result
   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> (rsp_valid && rsp_data.last))
      else $error("flush did not present a final result");

   // a new result never pushes out one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && status.cur_hit && status.pend_valid) |-> status.out_free)
      else $error("held result pushed into an occupied output");

   // requests that do not scan finish in the cycle they are taken
   a_single_cycle: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && !status.start_scan) |=> !req_stall)
      else $error("non-scanning request kept the block busy");

   // no scan activity while a request may be taken
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> (!cmd.step && !cmd.flush))
      else $error("scan command issued while idle");

endmodule : periodic_slot_dispatcher
`default_nettype wire

// File: sim/periodic_slot_dispatcher_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_slot_dispatcher_test
// self-checking bench for the periodic slot dispatcher: a shadow slot table
// in the bench works out the due reports of every accepted request, and each
// report leaving the block is compared with the oldest one waiting. Directed
// edge cases come first, then a held-off result side, then random schedules
// with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module periodic_slot_dispatcher_test;
   import psd_pkg::*;

   localparam int SLOTS         = 4;
   localparam int FIRE_LIMIT    = 4;
   localparam int MAX_GAP       = 18;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_STRETCH  = 300;
   localparam int IDLE_LIMIT    = 3000;
   localparam int RANDOM_PHASES = 7;
   localparam int PHASE_ITEMS   = 55;
   localparam int SHOWN_ERRORS  = 10;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   // shadow copy of the registers and of the slot table
   logic [CNT_W-1:0]     cfg_active;
   logic                 cfg_late_fires;
   logic [PERIOD_W-1:0]  cfg_period  [SLOTS];
   logic [TICK_W-1:0]    slot_due    [SLOTS];
   logic [TICK_W-1:0]    slot_misses [SLOTS];
   logic                 sched_running;
   logic                 sched_armed;

   // due reports still to come out of the block, oldest first
   rsp_type due_reports[$];

   int fail_count  = 0;
   int quiet_cycles = 0;
   int req_calm    = 0;   // requests left to send back to back
   int rsp_calm    = 0;   // results left to take without stalling
   int hold_cycles = 0;   // long hold-off asked of the result side

   periodic_slot_dispatcher dut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_data,
      .rsp_valid,
      .rsp_stall,
      .rsp_data,
      .csr_valid,
      .csr_ready,
      .csr_index,
      .csr_data
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // shadow slot table
   // -------------------------------------------------------------------------

   // active count saturates at the table size
   function automatic int slots_in_use();
      return (cfg_active > SLOTS) ? SLOTS : int'(cfg_active);
   endfunction

   task automatic arm_slots(input logic [TICK_W-1:0] now);
      int i;
      for (i = 0; i < slots_in_use(); i++)
         slot_due[i] = now + TICK_W'(cfg_period[i]);
   endtask

   // applies one request and queues the reports it causes
   task automatic step_slot_table(input req_type r);
      int            i;
      int            fired_cnt = 0;
      logic [31:0]   late;
      rsp_type       report;
      rsp_type       held;
      bit            have_held = 1'b0;
      case (r.operation)
         OP_INIT: begin
            // ignored while running, otherwise clears every slot first
            if (!sched_running) begin
               for (i = 0; i < SLOTS; i++) begin
                  slot_due[i]    = '0;
                  slot_misses[i] = '0;
               end
               arm_slots(r.now_tick);
               sched_armed = 1'b1;
            end
         end
         OP_START: begin
            if (!sched_running && sched_armed && slots_in_use() != 0) begin
               arm_slots(r.now_tick);
               sched_running = 1'b1;
            end
         end
         OP_STOP: begin
            sched_running = 1'b0;
         end
         default: begin
            if (sched_running) begin
               for (i = 0; i < slots_in_use() && fired_cnt < FIRE_LIMIT; i++) begin
                  late = r.now_tick - slot_due[i];
                  // zero period or not yet due by signed compare: no report
                  if (cfg_period[i] == '0 || late[TICK_W-1])
                     continue;
                  report = '0;
                  report.slot_id = SLOT_W'(i);
                  if (late >= TICK_W'(cfg_period[i])) begin
                     // late by a full period: count it and rearm from now
                     report.missed = 1'b1;
                     if (slot_misses[i] != MISS_MAX)
                        slot_misses[i] = slot_misses[i] + 1'b1;
                     if (cfg_late_fires) begin
                        report.fired = 1'b1;
                        fired_cnt++;
                     end
                     slot_due[i] = r.now_tick + TICK_W'(cfg_period[i]);
                  end else begin
                     report.fired = 1'b1;
                     fired_cnt++;
                     slot_due[i] = slot_due[i] + TICK_W'(cfg_period[i]);
                  end
                  report.miss_total = slot_misses[i];
                  // hold one back so the final one can be flagged
                  if (have_held)
                     due_reports.push_back(held);
                  held      = report;
                  have_held = 1'b1;
               end
               if (have_held) begin
                  held.last = 1'b1;
                  due_reports.push_back(held);
               end
            end
         end
      endcase
   endtask

   // -------------------------------------------------------------------------
   // channel drivers
   // -------------------------------------------------------------------------

   // one register write, valid stays high for a following write
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_ACTIVE_SLOTS: cfg_active     = value[CNT_W-1:0];
         CSR_LATE_FIRES:   cfg_late_fires = value[0];
         CSR_PERIOD_SLOT0: cfg_period[0]  = value[PERIOD_W-1:0];
         CSR_PERIOD_SLOT1: cfg_period[1]  = value[PERIOD_W-1:0];
         CSR_PERIOD_SLOT2: cfg_period[2]  = value[PERIOD_W-1:0];
         CSR_PERIOD_SLOT3: cfg_period[3]  = value[PERIOD_W-1:0];
         default: ;
      endcase
   endtask

   // writes every register, with random bits above each field
   task automatic program_slots(input logic [CNT_W-1:0] active, input logic late_fires,
                                input logic [SLOTS-1:0][PERIOD_W-1:0] periods);
      int i;
      write_csr(CSR_ACTIVE_SLOTS, {29'($urandom()), active});
      write_csr(CSR_LATE_FIRES, {31'($urandom()), late_fires});
      for (i = 0; i < SLOTS; i++)
         write_csr(CSR_PERIOD_SLOT0 + CSR_IDX_W'(i), {1'($urandom()), periods[i]});
      csr_valid <= 1'b0;
   endtask

   // offers one request after a random gap and waits for its transfer;
   // valid is left high so a request with no gap follows without a bubble
   task automatic send_request(input op_type op, input logic [TICK_W-1:0] now);
      int      gap;
      req_type r;
      if (req_calm > 0) begin
         gap = 0;
         req_calm--;
      end else begin
         gap = $urandom_range(0, MAX_GAP);
         if ($urandom_range(0, 15) == 0)
            req_calm = $urandom_range(8, 30);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      r.operation = op;
      r.now_tick  = now;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      step_slot_table(r);
   endtask

   // stop offering, let every report come out, then let a silent scan finish
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (due_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // result side: random stall before each result, calm stretches,
   // and the long hold-off when one is asked for
   initial begin : result_sink
      int pause;
      forever begin
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end else begin
            if (rsp_calm > 0) begin
               pause = 0;
               rsp_calm--;
            end else begin
               pause = $urandom_range(0, MAX_GAP);
               if ($urandom_range(0, 15) == 0)
                  rsp_calm = $urandom_range(8, 30);
            end
            if (pause > 0) begin
               rsp_stall <= 1'b1;
               repeat (pause) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1 && hold_cycles == 0);
      end
   end

   // each result transfer against the oldest waiting report
   always @(posedge clock) begin : report_check
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (due_reports.size() == 0) begin
            fail_count++;
            if (fail_count <= SHOWN_ERRORS) begin
               $display("%0t: result with none due", $time);
               $display("   got      slot %0d fired %0d missed %0d total %0h last %0d",
                        rsp_data.slot_id, rsp_data.fired, rsp_data.missed,
                        rsp_data.miss_total, rsp_data.last);
            end
         end else begin
            want = due_reports.pop_front();
            if (rsp_data.slot_id !== want.slot_id || rsp_data.fired !== want.fired ||
                rsp_data.missed !== want.missed || rsp_data.miss_total !== want.miss_total ||
                rsp_data.last !== want.last) begin
               fail_count++;
               if (fail_count <= SHOWN_ERRORS) begin
                  $display("%0t: report mismatch", $time);
                  $display("   expected slot %0d fired %0d missed %0d total %0h last %0d",
                           want.slot_id, want.fired, want.missed,
                           want.miss_total, want.last);
                  $display("   got      slot %0d fired %0d missed %0d total %0h last %0d",
                           rsp_data.slot_id, rsp_data.fired, rsp_data.missed,
                           rsp_data.miss_total, rsp_data.last);
               end
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // tests
   // -------------------------------------------------------------------------

   // registers still at reset: no slot in use, nothing may come out
   task automatic test_unarmed_ops();
      send_request(OP_DISPATCH, 32'h0);   // dispatch while stopped
      send_request(OP_START, 32'h0);      // start before any init
      send_request(OP_STOP, 32'h0);       // stop while stopped
      send_request(OP_INIT, 32'h5);       // init with no active slot
      send_request(OP_START, 32'h5);      // start with active count zero
      wait_idle();
   endtask

   // field extremes, every operation and the ignored cases
   task automatic test_slot_table_edges();
      logic [TICK_W-1:0] base;
      base = 32'hFFFF_FFF0;   // due times wrap through zero
      // slot 0 skipped, slot 1 shortest, slot 2 longest period
      program_slots(3'd4, 1'b0, {31'd10, 31'h7FFF_FFFF, 31'd1, 31'd0});
      send_request(OP_INIT, base);
      send_request(OP_DISPATCH, base);         // armed but not running
      send_request(OP_START, base);
      send_request(OP_INIT, base + 100);       // init while running
      send_request(OP_START, base + 100);      // start while running
      send_request(OP_DISPATCH, base);         // nothing due yet
      send_request(OP_DISPATCH, base + 1);     // on time
      send_request(OP_DISPATCH, base + 10);    // miss and on time together
      send_request(OP_DISPATCH, base + 40);    // both late by a period
      send_request(OP_STOP, base);
      send_request(OP_DISPATCH, base + 50);
      send_request(OP_STOP, base);
      wait_idle();
      // active count above the table size, missed slots fire too
      program_slots(3'd7, 1'b1, {31'd0, 31'd1, 31'h7FFF_FFFF, 31'd3});
      send_request(OP_INIT, 32'h0);
      send_request(OP_START, 32'h0);
      send_request(OP_DISPATCH, 32'h7FFF_FFFF);
      send_request(OP_DISPATCH, 32'hFFFF_FFFF);
      send_request(OP_STOP, 32'h0);
      wait_idle();
   endtask

   // result side held off while requests keep coming, every slot due each time
   task automatic test_result_holdoff();
      logic [TICK_W-1:0] t;
      int k;
      t = $urandom();
      program_slots(3'd4, 1'b0, {SLOTS{31'd1}});
      send_request(OP_INIT, t);
      send_request(OP_START, t);
      hold_cycles = HOLD_STRETCH;
      req_calm    = 24;
      for (k = 1; k <= 24; k++)
         send_request(OP_DISPATCH, t + k);
      // sender waits here for every report
      wait_idle();
   endtask

   // random register settings, ticks mostly walking near the due times
   task automatic test_random_schedules();
      logic [SLOTS-1:0][PERIOD_W-1:0] periods;
      logic [CNT_W-1:0]               active;
      logic [TICK_W-1:0]              tick;
      int phase, k, i, pick;
      tick = $urandom();
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         pick = $urandom_range(0, 9);
         if (pick == 0)
            active = '0;
         else if (pick < 8)
            active = CNT_W'($urandom_range(1, SLOTS));
         else
            active = CNT_W'($urandom_range(SLOTS + 1, 7));
         for (i = 0; i < SLOTS; i++) begin
            pick = $urandom_range(0, 19);
            if (pick < 3)
               periods[i] = '0;
            else if (pick == 3)
               periods[i] = 31'h7FFF_FFFF;
            else if (pick == 4)
               periods[i] = 31'($urandom());
            else
               periods[i] = 31'($urandom_range(1, 40));
         end
         program_slots(active, 1'($urandom()), periods);
         send_request(OP_INIT, tick);
         send_request(OP_START, tick);
         for (k = 0; k < PHASE_ITEMS; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 82) begin
               pick = $urandom_range(0, 99);
               if (pick < 70)
                  tick = tick + $urandom_range(0, 50);
               else if (pick < 80)
                  tick = tick - $urandom_range(1, 30);    // back before the due time
               else if (pick < 90)
                  tick = tick + $urandom();
               else
                  tick = $urandom();
               send_request(OP_DISPATCH, tick);
            end else if (pick < 87) begin
               // stop, a dispatch that must be ignored, and start again
               send_request(OP_STOP, tick);
               send_request(OP_DISPATCH, tick);
               send_request(OP_START, tick);
            end else if (pick < 92) begin
               send_request(OP_INIT, tick);
            end else if (pick < 96) begin
               send_request(OP_START, tick);
            end else begin
               // sender pauses until the block has drained
               wait_idle();
               tick = tick + $urandom_range(0, 50);
               send_request(OP_DISPATCH, tick);
            end
         end
         wait_idle();
      end
   endtask

   initial begin : main
      int i;
      cfg_active     = '0;
      cfg_late_fires = 1'b0;
      for (i = 0; i < SLOTS; i++) begin
         cfg_period[i]  = '0;
         slot_due[i]    = '0;
         slot_misses[i] = '0;
      end
      sched_running = 1'b0;
      sched_armed   = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_unarmed_ops();
      test_slot_table_edges();
      test_result_holdoff();
      test_random_schedules();

      wait_idle();
      fail_count = fail_count + due_reports.size();
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
